// ===== rtl/tsgtq_pkg.sv =====
`default_nettype none

package tsgtq_pkg;

  // field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ENTRY_W  = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned QCOUNT_W = 3;
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned NSLOT_W  = 8;
  localparam int unsigned GUARD_W  = 15;
  localparam int unsigned CFG_IDX_W = 3;

  // divider geometry: one quotient bit per step
  localparam int unsigned DIV_STEPS  = TIME_W;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

  // register reset values
  localparam logic [WIDTH_W-1:0] SLOT_WIDTH_RST = 16'd900;
  localparam logic [NSLOT_W-1:0] NUM_SLOTS_RST  = 8'd2;
  localparam logic [NSLOT_W-1:0] MY_SLOT_RST    = 8'd0;
  localparam logic [GUARD_W-1:0] GUARD_RST      = 15'd20;
  localparam logic [TIME_W-1:0]  STALE_RST      = 32'd300000;
  localparam logic [TIME_W-1:0]  LAST_SLOT_RST  = 32'hFFFF_FFFF;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_POLL = 2'd0,
    KIND_SYNC = 2'd1,
    KIND_ENQ  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_WIDTH = 3'd0,
    CFG_NUM_SLOTS  = 3'd1,
    CFG_MY_SLOT    = 3'd2,
    CFG_GUARD      = 3'd3,
    CFG_STALE      = 3'd4
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_PREP,
    ST_SLOT_GO,
    ST_SLOT_WAIT,
    ST_FRAME_GO,
    ST_FRAME_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  sync_time_ms;
    logic [ENTRY_W-1:0] entry;
  } in_beat_t;

  typedef struct packed {
    logic                sent;
    logic [ENTRY_W-1:0]  sent_entry;
    logic                evicted;
    logic [QCOUNT_W-1:0] queue_count;
    logic [TIME_W-1:0]   slot_number;
  } out_beat_t;

  // queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tsgtq_div.sv =====
`default_nettype none

module tsgtq_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tsgtq_pkg::TIME_W-1:0]  dividend_i,
  input  logic [tsgtq_pkg::WIDTH_W-1:0] divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [tsgtq_pkg::TIME_W-1:0]  quotient_o,
  output logic [tsgtq_pkg::WIDTH_W-1:0] remainder_o
);
  import tsgtq_pkg::*;

  logic                  busy_q, done_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic [TIME_W-1:0]     quo_q;
  logic [WIDTH_W-1:0]    rem_q;
  logic [WIDTH_W-1:0]    dsr_q;
  logic [WIDTH_W:0]      trial;
  logic [WIDTH_W+1:0]    diff;
  logic                  ge;

  // restoring step: shift in next dividend bit, trial subtract
  assign trial = {rem_q, quo_q[TIME_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};
  assign ge    = ~diff[WIDTH_W+1];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      quo_q <= {quo_q[TIME_W-2:0], ge};
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/tsgtq_queue.sv =====
`default_nettype none

module tsgtq_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned CNT_W = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsgtq_pkg::q_ctrl_t            ctrl_i,
  input  logic [tsgtq_pkg::ENTRY_W-1:0] wdata_i,
  output logic [tsgtq_pkg::ENTRY_W-1:0] rdata_o,
  output logic [CNT_W-1:0]              count_o,
  output logic [CNT_W-1:0]              count_next_o
);
  import tsgtq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [PTR_W-1:0]   head_q, tail_q;
  logic [CNT_W-1:0]   count_q, count_d;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else                        r = p + 1'b1;
    return r;
  endfunction

  // occupancy after this cycle's push and pop
  always_comb begin
    count_d = count_q;
    if (ctrl_i.push && !ctrl_i.pop) count_d = count_q + 1'b1;
    if (!ctrl_i.push && ctrl_i.pop) count_d = count_q - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (ctrl_i.pop)  head_q <= wrap_inc(head_q);
      if (ctrl_i.push) tail_q <= wrap_inc(tail_q);
      count_q <= count_d;
    end
  end

  // storage, head read registered
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) mem[tail_q] <= wdata_i;
    rdata_q <= mem[head_q];
  end

  assign rdata_o      = rdata_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

`default_nettype wire

// ===== rtl/tdma_slot_gated_tx_queue_core.sv =====
`default_nettype none

// TDMA slot-gated transmit queue.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one beat per item:
// poll, sync, enqueue or no-op. Output channel (out_valid_o/out_ready_i,
// out_data_o) returns exactly one result beat per item, in order.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i), to be
// written only while the block is idle; the user must keep to this, as the block does not enforce it.
// Sync, enqueue and no-op go from accept straight to the finish state.
// A poll runs a 32-step serial divide (session time by slot width); with a
// current sync it runs a second 32-step divide (slot by frame length).
// The shared divider yields one quotient bit per cycle; one item is in work
// at a time.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished item holds until the register
// frees and input stays not ready meanwhile.
// Reset empties the queue, drops the sync and restores register defaults.
module tdma_slot_gated_tx_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tsgtq_pkg::in_beat_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tsgtq_pkg::out_beat_t            out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tsgtq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsgtq_pkg::TIME_W-1:0]    cfg_wdata_i
);
  import tsgtq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [WIDTH_W-1:0] slot_width_q;
  logic [NSLOT_W-1:0] num_slots_q;
  logic [NSLOT_W-1:0] my_slot_q;
  logic [GUARD_W-1:0] guard_q;
  logic [TIME_W-1:0]  stale_q;

  // sync and gating state
  logic [TIME_W-1:0]  sync_session_q, sync_local_q;
  logic               has_synced_q;
  logic [TIME_W-1:0]  last_slot_q;

  // per-item working registers
  state_e             state_q, state_d;
  in_beat_t           item_q;
  logic [TIME_W-1:0]  age_q;
  logic               unsynced_q;
  logic [TIME_W-1:0]  dividend_q;
  logic [TIME_W-1:0]  slot_q;
  logic [WIDTH_W-1:0] pos_q;
  logic [NSLOT_W-1:0] frame_rem_q;

  // output register
  logic               out_valid_q;
  out_beat_t          out_q, out_d;

  // control
  logic               accept, fire, div_start;
  logic               div_busy, div_done;
  logic [TIME_W-1:0]  div_quo;
  logic [WIDTH_W-1:0] div_rem;
  logic [TIME_W-1:0]  div_dividend;
  logic [WIDTH_W-1:0] div_divisor;
  logic [WIDTH_W-1:0] width_eff;
  logic [NSLOT_W-1:0] nslots_eff;
  logic               may_send, do_send, is_full;
  logic [WIDTH_W:0]   pos_end;
  q_ctrl_t            q_ctrl;
  logic [ENTRY_W-1:0] head_entry;
  logic [CNT_W-1:0]   q_count, q_count_next;
  logic [CNT_W+2:0]   q_count_ext;

  assign width_eff  = (slot_width_q == '0) ? WIDTH_W'(1) : slot_width_q;
  assign nslots_eff = (num_slots_q == '0) ? NSLOT_W'(1) : num_slots_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_width_q <= SLOT_WIDTH_RST;
      num_slots_q  <= NUM_SLOTS_RST;
      my_slot_q    <= MY_SLOT_RST;
      guard_q      <= GUARD_RST;
      stale_q      <= STALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOT_WIDTH: slot_width_q <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_NUM_SLOTS:  num_slots_q  <= cfg_wdata_i[NSLOT_W-1:0];
        CFG_MY_SLOT:    my_slot_q    <= cfg_wdata_i[NSLOT_W-1:0];
        CFG_GUARD:      guard_q      <= cfg_wdata_i[GUARD_W-1:0];
        CFG_STALE:      stale_q      <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (kind_e'(in_data_i.kind) == KIND_POLL) ? ST_AGE : ST_FINISH;
        end
      end
      ST_AGE:       state_d = ST_PREP;
      ST_PREP:      state_d = ST_SLOT_GO;
      ST_SLOT_GO:   state_d = ST_SLOT_WAIT;
      ST_SLOT_WAIT: begin
        if (div_done) state_d = unsynced_q ? ST_FINISH : ST_FRAME_GO;
      end
      ST_FRAME_GO:  state_d = ST_FRAME_WAIT;
      ST_FRAME_WAIT: begin
        if (div_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fire) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    div_start    = 1'b0;
    fire         = 1'b0;
    div_dividend = slot_q;
    div_divisor  = {{(WIDTH_W-NSLOT_W){1'b0}}, nslots_eff};
    case (state_q)
      ST_IDLE:     in_ready_o = 1'b1;
      ST_SLOT_GO: begin
        div_start    = 1'b1;
        div_dividend = dividend_q;
        div_divisor  = width_eff;
      end
      ST_FRAME_GO: div_start = 1'b1;
      ST_FINISH:   fire = !out_valid_q || out_ready_i;
      default:     ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // working registers along the poll sequence
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == ST_AGE) age_q <= item_q.now_ms - sync_local_q;
    if (state_q == ST_PREP) begin
      unsynced_q <= !has_synced_q || (age_q > stale_q);
      dividend_q <= (!has_synced_q || (age_q > stale_q)) ? item_q.now_ms
                                                         : sync_session_q + age_q;
    end
    if (state_q == ST_SLOT_WAIT && div_done) begin
      slot_q <= div_quo;
      pos_q  <= div_rem;
    end
    if (state_q == ST_FRAME_WAIT && div_done) frame_rem_q <= div_rem[NSLOT_W-1:0];
  end

  // gating decision
  assign pos_end  = {1'b0, pos_q} + {2'b00, guard_q};
  assign may_send = unsynced_q ||
                    ((frame_rem_q == my_slot_q) &&
                     (pos_q >= {1'b0, guard_q}) &&
                     (pos_end < {1'b0, width_eff}));
  assign do_send  = (q_count != '0) && may_send && (slot_q != last_slot_q);
  assign is_full  = (q_count == CNT_W'(QUEUE_DEPTH));

  // queue operations for the finishing item
  always_comb begin
    q_ctrl = '0;
    if (fire) begin
      case (kind_e'(item_q.kind))
        KIND_POLL: q_ctrl.pop = do_send;
        KIND_ENQ: begin
          q_ctrl.push = 1'b1;
          q_ctrl.pop  = is_full;
        end
        default: ;
      endcase
    end
  end

  assign q_count_ext = {3'b000, q_count_next};

  // result beat
  always_comb begin
    out_d             = '0;
    out_d.queue_count = q_count_ext[QCOUNT_W-1:0];
    case (kind_e'(item_q.kind))
      KIND_POLL: begin
        out_d.slot_number = slot_q;
        out_d.sent        = do_send;
        out_d.sent_entry  = do_send ? head_entry : '0;
      end
      KIND_ENQ:  out_d.evicted = is_full;
      default:   ;
    endcase
  end

  // sync, last slot and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_session_q <= '0;
      sync_local_q   <= '0;
      has_synced_q   <= 1'b0;
      last_slot_q    <= LAST_SLOT_RST;
      out_valid_q    <= 1'b0;
    end else begin
      if (fire && kind_e'(item_q.kind) == KIND_SYNC) begin
        sync_session_q <= item_q.sync_time_ms;
        sync_local_q   <= item_q.now_ms;
        has_synced_q   <= 1'b1;
      end
      if (fire && kind_e'(item_q.kind) == KIND_POLL && do_send) last_slot_q <= slot_q;
      if (fire)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  tsgtq_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  tsgtq_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CNT_W (CNT_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (q_ctrl),
    .wdata_i      (item_q.entry),
    .rdata_o      (head_entry),
    .count_o      (q_count),
    .count_next_o (q_count_next)
  );

`ifndef ASSERT_OFF
  // occupancy never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // divider is never restarted while a division is in progress
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a release records its slot so the same slot cannot release again
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && q_ctrl.pop && kind_e'(item_q.kind) == KIND_POLL) |=>
      (last_slot_q == $past(slot_q)))
    else $error("last slot not updated on release");

  // a pop never happens on an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctrl.pop |-> (q_count != '0))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
